/* src/bal_pkg.sv */
// Shared types, register codes, constants and base-scoring helpers for the aligner.
package bal_pkg;

	localparam int QUERY_MAX_DEF     = 256;
	localparam int REFERENCE_MAX_DEF = 4096;
	localparam int SCORE_BITS_DEF    = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_OPEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_EXT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_QLEN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_HW  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_DG  = 3'd6;

	localparam logic [7:0] BASE_A = 8'h41;
	localparam logic [7:0] BASE_C = 8'h43;
	localparam logic [7:0] BASE_G = 8'h47;
	localparam logic [7:0] BASE_T = 8'h54;

	typedef struct packed {
		logic signed [7:0]  match_award;
		logic signed [7:0]  mismatch_penalty;
		logic signed [7:0]  gap_open_cost;
		logic signed [7:0]  gap_extend_cost;
		logic        [8:0]  query_length;
		logic signed [13:0] band_half_width;
		logic signed [12:0] band_diagonal;
	} cfg_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	function automatic logic is_acgt(input logic [7:0] b);
		return (b == BASE_A) || (b == BASE_C) || (b == BASE_G) || (b == BASE_T);
	endfunction

	// substitution delta for one query/reference pair
	function automatic logic signed [7:0] subst(input logic [7:0] q, input logic [7:0] r,
			input logic signed [7:0] m, input logic signed [7:0] mm);
		logic signed [7:0] d;
		if (q == r && is_acgt(q)) begin
			d = m;
		end else if (!is_acgt(q) || !is_acgt(r)) begin
			d = 8'sd0;
		end else begin
			d = mm;
		end
		return d;
	endfunction

endpackage

/* src/banded_affine_local_aligner.sv */
// Top level: banded affine-gap local aligner built as a chain of query-row cells.
// Timing: a query load takes effect at the accepting edge; a reference byte sweeps the
//   chain one row per cycle, and busy stays high until it reaches the chain end.
// A new reference byte is accepted only after the previous one reaches the chain end.
// The result strobe (done) is registered when the last reference byte leaves the chain,
//   or in the next cycle past the reference limit; the receiver cannot stall it.
// Reset (arst_n low) restores register defaults and clears the cell scores and the best cell.
module banded_affine_local_aligner #(
	parameter int QUERY_MAX     = bal_pkg::QUERY_MAX_DEF,
	parameter int REFERENCE_MAX = bal_pkg::REFERENCE_MAX_DEF,
	parameter int SCORE_BITS    = bal_pkg::SCORE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr,
	input  logic [bal_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [bal_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             start,
	output logic                             busy,
	input  logic                             mode,
	input  logic [7:0]                       query_index,
	input  logic [7:0]                       base_byte,
	input  logic                             last_reference,
	output logic                             done,
	output logic                             found,
	output logic [14:0]                      peak_score,
	output logic [8:0]                       end_row,
	output logic [12:0]                      end_col
);
	import bal_pkg::*;

	localparam int SB  = SCORE_BITS;
	localparam int QIW = $clog2(QUERY_MAX + 1);
	localparam int RW  = $clog2(REFERENCE_MAX + 1);
	localparam int OW  = RW + 16;
	localparam logic signed [SB-1:0] FLOOR = SB'(-(longint'(1) << (SB - 2)));

	// chain links: index k feeds cell k, index QUERY_MAX is the chain end
	logic                 tv   [0:QUERY_MAX];
	logic [7:0]           rb   [0:QUERY_MAX];
	logic [RW-1:0]        col  [0:QUERY_MAX];
	logic signed [OW-1:0] off  [0:QUERY_MAX];
	logic signed [SB-1:0] uph  [0:QUERY_MAX];
	logic signed [SB-1:0] upg  [0:QUERY_MAX];
	logic signed [SB-1:0] dg   [0:QUERY_MAX];
	logic signed [SB-1:0] bs   [0:QUERY_MAX];
	logic [QIW-1:0]       br   [0:QUERY_MAX];
	logic [RW-1:0]        bc   [0:QUERY_MAX];

	cfg_t                 cfg_q;
	state_t               state_q, state_d;
	logic [RW-1:0]        pos_q;
	logic signed [SB-1:0] best_s_q;
	logic [QIW-1:0]       best_r_q;
	logic [RW-1:0]        best_c_q;
	logic                 last_q;

	// launch stage into the first cell
	logic                 l_valid_q;
	logic [7:0]           l_ref_q;
	logic [RW-1:0]        l_col_q;
	logic signed [OW-1:0] l_off_q;

	logic                 done_q, found_q;
	logic [14:0]          score_q;
	logic [8:0]           qend_q;
	logic [12:0]          rend_q;

	logic accept, launch, overflow_emit, chain_end, end_emit, clear;
	logic signed [SB-1:0] em_s;
	logic [QIW-1:0]       em_r;
	logic [RW-1:0]        em_c;
	logic [RW-1:0]        next_col;

	assign accept        = start && (state_q == ST_IDLE);
	assign launch        = accept && mode && (pos_q < RW'(REFERENCE_MAX));
	assign overflow_emit = accept && mode && !(pos_q < RW'(REFERENCE_MAX)) && last_reference;
	assign chain_end     = tv[QUERY_MAX];
	assign end_emit      = chain_end && last_q;
	assign clear         = overflow_emit || end_emit;
	assign next_col      = pos_q + RW'(1);

	// result comes from the chain when the last column just finished, else from the held best
	assign em_s = end_emit ? bs[QUERY_MAX] : best_s_q;
	assign em_r = end_emit ? br[QUERY_MAX] : best_r_q;
	assign em_c = end_emit ? bc[QUERY_MAX] : best_c_q;

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (launch) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				busy = 1'b1;
				if (chain_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// register file; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_award      <= 8'sd2;
			cfg_q.mismatch_penalty <= -8'sd3;
			cfg_q.gap_open_cost    <= -8'sd5;
			cfg_q.gap_extend_cost  <= -8'sd2;
			cfg_q.query_length     <= 9'd1;
			cfg_q.band_half_width  <= -14'sd1;
			cfg_q.band_diagonal    <= 13'sd0;
		end else if (cfg_wr) begin
			case (cfg_addr)
				REG_MATCH:    cfg_q.match_award      <= cfg_wdata[7:0];
				REG_MISMATCH: cfg_q.mismatch_penalty <= cfg_wdata[7:0];
				REG_GAP_OPEN: cfg_q.gap_open_cost    <= cfg_wdata[7:0];
				REG_GAP_EXT:  cfg_q.gap_extend_cost  <= cfg_wdata[7:0];
				REG_QLEN:     cfg_q.query_length     <= cfg_wdata[8:0];
				REG_BAND_HW:  cfg_q.band_half_width  <= cfg_wdata[13:0];
				REG_BAND_DG:  cfg_q.band_diagonal    <= cfg_wdata[12:0];
				default: begin
				end
			endcase
		end
	end

	// column position, best cell and pending-last flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			best_s_q  <= '0;
			best_r_q  <= '0;
			best_c_q  <= '0;
			last_q    <= 1'b0;
			l_valid_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			l_valid_q <= launch;
			done_q    <= clear;
			if (launch) begin
				pos_q  <= next_col;
				last_q <= last_reference;
			end
			if (clear) begin
				pos_q    <= '0;
				best_s_q <= '0;
				best_r_q <= '0;
				best_c_q <= '0;
			end else if (chain_end) begin
				best_s_q <= bs[QUERY_MAX];
				best_r_q <= br[QUERY_MAX];
				best_c_q <= bc[QUERY_MAX];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			l_ref_q <= base_byte;
			l_col_q <= next_col;
			// band offset for row one: column - 1 + diagonal
			l_off_q <= OW'(signed'({1'b0, next_col})) - OW'(1) + OW'(cfg_q.band_diagonal);
		end
		if (clear) begin
			found_q <= (em_s != '0);
			score_q <= (em_s != '0) ? 15'(em_s) : '0;
			qend_q  <= (em_s != '0) ? 9'(em_r) : '0;
			rend_q  <= (em_s != '0) ? 13'(em_c) : '0;
		end
	end

	assign tv[0]   = l_valid_q;
	assign rb[0]   = l_ref_q;
	assign col[0]  = l_col_q;
	assign off[0]  = l_off_q;
	assign uph[0]  = '0;
	assign upg[0]  = FLOOR;
	assign dg[0]   = '0;
	assign bs[0]   = best_s_q;
	assign br[0]   = best_r_q;
	assign bc[0]   = best_c_q;

	for (genvar k = 0; k < QUERY_MAX; k++) begin : g_row
		bal_cell #(
			.ROW (k + 1),
			.SB  (SB),
			.QIW (QIW),
			.RW  (RW),
			.OW  (OW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg_q),
			.clear     (clear),
			.qwr       (accept && !mode),
			.qwr_index (query_index),
			.qwr_byte  (base_byte),
			.tv_i      (tv[k]),
			.ref_i     (rb[k]),
			.col_i     (col[k]),
			.off_i     (off[k]),
			.uph_i     (uph[k]),
			.upg_i     (upg[k]),
			.diag_i    (dg[k]),
			.bs_i      (bs[k]),
			.br_i      (br[k]),
			.bc_i      (bc[k]),
			.tv_o      (tv[k+1]),
			.ref_o     (rb[k+1]),
			.col_o     (col[k+1]),
			.off_o     (off[k+1]),
			.uph_o     (uph[k+1]),
			.upg_o     (upg[k+1]),
			.diag_o    (dg[k+1]),
			.bs_o      (bs[k+1]),
			.br_o      (br[k+1]),
			.bc_o      (bc[k+1])
		);
	end

	assign done       = done_q;
	assign found      = found_q;
	assign peak_score = score_q;
	assign end_row    = qend_q;
	assign end_col    = rend_q;

endmodule

/* src/bal_cell.sv */
// One query-row cell: holds the row's base, cell score and deletion score.
module bal_cell #(
	parameter int ROW = 1,
	parameter int SB  = 16,
	parameter int QIW = 9,
	parameter int RW  = 13,
	parameter int OW  = 29
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bal_pkg::cfg_t       cfg,
	input  logic                clear,
	input  logic                qwr,
	input  logic [7:0]          qwr_index,
	input  logic [7:0]          qwr_byte,
	input  logic                tv_i,
	input  logic [7:0]          ref_i,
	input  logic [RW-1:0]       col_i,
	input  logic signed [OW-1:0] off_i,
	input  logic signed [SB-1:0] uph_i,
	input  logic signed [SB-1:0] upg_i,
	input  logic signed [SB-1:0] diag_i,
	input  logic signed [SB-1:0] bs_i,
	input  logic [QIW-1:0]      br_i,
	input  logic [RW-1:0]       bc_i,
	output logic                tv_o,
	output logic [7:0]          ref_o,
	output logic [RW-1:0]       col_o,
	output logic signed [OW-1:0] off_o,
	output logic signed [SB-1:0] uph_o,
	output logic signed [SB-1:0] upg_o,
	output logic signed [SB-1:0] diag_o,
	output logic signed [SB-1:0] bs_o,
	output logic [QIW-1:0]      br_o,
	output logic [RW-1:0]       bc_o
);
	import bal_pkg::*;

	localparam int SW = SB + 1;
	localparam longint FLOOR_L = -(longint'(1) << (SB - 2));
	localparam longint CEIL_L  = (longint'(1) << (SB - 1)) - 1;
	localparam logic signed [SB-1:0] FLOOR = SB'(FLOOR_L);

	function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] a,
			input logic signed [7:0] b);
		logic signed [SW-1:0] s;
		logic signed [SB-1:0] r;
		s = SW'(a) + SW'(b);
		if (s < SW'(FLOOR_L)) begin
			r = FLOOR;
		end else if (s > SW'(CEIL_L)) begin
			r = SB'(CEIL_L);
		end else begin
			r = SB'(s);
		end
		return r;
	endfunction

	function automatic logic signed [SB-1:0] smax(input logic signed [SB-1:0] a,
			input logic signed [SB-1:0] b);
		return (a > b) ? a : b;
	endfunction

	logic [7:0]          qbase_q;
	logic signed [SB-1:0] h_q;
	logic signed [SB-1:0] e_q;

	logic                 in_band;
	logic signed [OW-1:0] hw_ext;
	logic signed [SB-1:0] ins, del, sub, score;
	logic                 take;

	always_comb begin
		hw_ext = OW'(cfg.band_half_width);
		in_band = ((QIW + 9)'(ROW) <= (QIW + 9)'(cfg.query_length));
		if (in_band && !cfg.band_half_width[13]) begin
			in_band = (off_i >= -hw_ext) && (off_i <= hw_ext);
		end
		ins   = smax(sat_add(upg_i, cfg.gap_extend_cost), sat_add(uph_i, cfg.gap_open_cost));
		del   = smax(sat_add(e_q, cfg.gap_extend_cost), sat_add(h_q, cfg.gap_open_cost));
		sub   = sat_add(diag_i, subst(qbase_q, ref_i, cfg.match_award, cfg.mismatch_penalty));
		score = smax(smax('0, sub), smax(ins, del));
		take  = in_band && ((score > bs_i) ||
			(score == bs_i && score > 0 && (QIW + 1)'(ROW) < (QIW + 1)'(br_i)));
	end

	// query byte, written by index during load
	always_ff @(posedge clk) begin
		if (qwr && (ROW - 1) < 256 && qwr_index == 8'(ROW - 1)) begin
			qbase_q <= qwr_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q  <= '0;
			e_q  <= FLOOR;
			tv_o <= 1'b0;
		end else begin
			tv_o <= tv_i;
			if (clear) begin
				h_q <= '0;
				e_q <= FLOOR;
			end else if (tv_i) begin
				h_q <= in_band ? score : '0;
				e_q <= in_band ? del : FLOOR;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tv_i) begin
			ref_o  <= ref_i;
			col_o  <= col_i;
			off_o  <= off_i - OW'(1);
			uph_o  <= in_band ? score : '0;
			upg_o  <= in_band ? ins : FLOOR;
			diag_o <= h_q;
			bs_o   <= take ? score : bs_i;
			br_o   <= take ? QIW'(ROW) : br_i;
			bc_o   <= take ? col_i : bc_i;
		end
	end

endmodule

/* src/bal_checker.sv */
// Port-level checker for the aligner, bound to the top level.
module bal_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        found,
	input logic [14:0] peak_score,
	input logic [8:0]  end_row,
	input logic [12:0] end_col
);

	// busy only ever begins after a transfer
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

	// a result follows either a sweep or a directly accepted byte
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result without preceding work");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> peak_score == 15'd0 && end_row == 9'd0 && end_col == 13'd0)
		else $error("not-found result carries non-zero fields");

	a_found_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> peak_score != 15'd0 && end_row != 9'd0 && end_col != 13'd0)
		else $error("found result carries a zero field");

endmodule

bind banded_affine_local_aligner bal_checker u_bal_checker (.*);
